/* design/pointer_allocation_tracker_macros.svh */
// Assertion macros for the pointer allocation tracker.
`ifndef POINTER_ALLOCATION_TRACKER_MACROS_SVH
`define POINTER_ALLOCATION_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clock, off during reset.
`define PAT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pointer tracker check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define PAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pointer tracker check failed");

`else

`define PAT_ASSERT_NOW(label, ante, cons)
`define PAT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/pat_pkg.sv */
// Shared types, codes and hash rounds for the pointer allocation tracker.
package pat_pkg;

   localparam int PTR_W    = 64;
   localparam int ANCHOR_W = 16;
   localparam int STATUS_W = 3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_RECORDED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNTRACKED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 3'd4;

   localparam logic [ANCHOR_W-1:0] NO_ANCHOR = 16'hFFFF;

   localparam logic [1:0] MIX_LAST = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIX,
      ST_ISSUE,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [PTR_W-1:0]    ptr;
      logic [ANCHOR_W-1:0] alloc_anchor;
      logic [ANCHOR_W-1:0] free_anchor;
   } slot_entry_type;

   // One of four rounds of the 64-bit integer mix.
   function automatic logic [PTR_W-1:0] mix_round(input logic [PTR_W-1:0] v,
                                                  input logic [1:0] round);
      logic [PTR_W-1:0] a;
      logic [PTR_W-1:0] r;
      a = '0;
      case (round)
         2'd0: begin
            a = ~v + (v << 21);
            r = a ^ (a >> 24);
         end
         2'd1: begin
            a = v + (v << 3) + (v << 8);
            r = a ^ (a >> 14);
         end
         2'd2: begin
            a = v + (v << 2) + (v << 4);
            r = a ^ (a >> 28);
         end
         default: begin
            r = v + (v << 31);
         end
      endcase
      return r;
   endfunction

endpackage

/* design/pointer_allocation_tracker.sv */
// Flow: a null pointer goes straight to its result; any other pointer passes 4 hash rounds,
// a read issue and n probes, n = slots probed (1 to TABLE_SLOTS + 2), before its result.
// One request at a time: the next is taken only after the last has reached its result.
// A result waiting on rsp_stall does not block the next request.
// Reset: synchronous; then a clearing pass zeroes the slot memory,
// and req_stall stays high until it ends.
`include "pointer_allocation_tracker_macros.svh"

module pointer_allocation_tracker
   import pat_pkg::*;
#(
   parameter int INDEX_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [PTR_W-1:0]    req_pointer,
   input  logic [ANCHOR_W-1:0] req_anchor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ANCHOR_W-1:0] rsp_alloc_anchor_seen,
   output logic [ANCHOR_W-1:0] rsp_free_anchor_seen
);

   localparam int TABLE_SLOTS = 1 << INDEX_BITS;
   localparam logic [INDEX_BITS-1:0] SLOT_LAST = {INDEX_BITS{1'b1}};
   // Home, second, then a full circle back to the second slot.
   localparam logic [INDEX_BITS:0] LAST_PROBE = (INDEX_BITS+1)'(TABLE_SLOTS + 1);

   slot_entry_type slot_mem [TABLE_SLOTS];

   state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]            mix_cnt_ff, mix_cnt_in;
   logic [INDEX_BITS:0]   cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0] cur_pos_ff, cur_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  cmd_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [ANCHOR_W-1:0]   anchor_ff;
   logic [PTR_W-1:0]      hash_ff;
   slot_entry_type        rdata_ff;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ANCHOR_W-1:0]   res_alloc_ff, res_alloc_in;
   logic [ANCHOR_W-1:0]   res_free_ff, res_free_in;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ANCHOR_W-1:0]   rsp_alloc_ff;
   logic [ANCHOR_W-1:0]   rsp_free_ff;

   logic                  req_take;
   logic                  out_free;
   logic [INDEX_BITS-1:0] home_idx;
   logic [INDEX_BITS-1:0] second_idx;
   logic [INDEX_BITS-1:0] next_pos;
   logic                  hit_match;
   logic                  hit_empty;
   logic                  exhausted;
   logic                  probe_done;

   logic                  rd_en;
   logic [INDEX_BITS-1:0] rd_addr;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   slot_entry_type        wr_data;

   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign home_idx   = hash_ff[INDEX_BITS-1:0];
   assign second_idx = home_idx + hash_ff[2*INDEX_BITS-1:INDEX_BITS];
   assign next_pos   = (cnt_ff == '0) ? second_idx : cur_pos_ff + INDEX_BITS'(1);
   assign hit_match  = rdata_ff.ptr == ptr_ff;
   assign hit_empty  = rdata_ff.ptr == '0;
   assign exhausted  = cnt_ff == LAST_PROBE;
   assign probe_done = hit_match || hit_empty || exhausted;

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SLOT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) state_in = (req_pointer == '0) ? ST_DONE : ST_MIX;
         end
         ST_MIX: begin
            if (mix_cnt_ff == MIX_LAST) state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (probe_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_stall     = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = next_pos;
      wr_en         = 1'b0;
      wr_addr       = cur_pos_ff;
      wr_data       = '0;
      clr_cnt_in    = clr_cnt_ff;
      mix_cnt_in    = mix_cnt_ff;
      cnt_in        = cnt_ff;
      cur_pos_in    = cur_pos_ff;
      res_status_in = res_status_ff;
      res_alloc_in  = res_alloc_ff;
      res_free_in   = res_free_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + INDEX_BITS'(1);
         end
         ST_IDLE: begin
            req_stall     = 1'b0;
            res_status_in = STATUS_NULL;
            res_alloc_in  = NO_ANCHOR;
            res_free_in   = NO_ANCHOR;
         end
         ST_MIX: begin
            mix_cnt_in = mix_cnt_ff + 2'd1;
         end
         ST_ISSUE: begin
            rd_en      = 1'b1;
            rd_addr    = home_idx;
            cnt_in     = '0;
            cur_pos_in = home_idx;
         end
         ST_PROBE: begin
            if (!probe_done) begin
               rd_en      = 1'b1;
               cnt_in     = cnt_ff + (INDEX_BITS+1)'(1);
               cur_pos_in = next_pos;
            end else if (cmd_ff == CMD_ALLOC) begin
               if (hit_match || hit_empty) begin
                  wr_en         = 1'b1;
                  wr_data       = '{ptr: ptr_ff, alloc_anchor: anchor_ff,
                                    free_anchor: NO_ANCHOR};
                  res_status_in = STATUS_RECORDED;
               end else begin
                  res_status_in = STATUS_FULL;
               end
            end else begin
               if (!hit_match) begin
                  res_status_in = STATUS_UNTRACKED;
               end else if (rdata_ff.free_anchor != NO_ANCHOR) begin
                  res_status_in = STATUS_DOUBLE;
                  res_alloc_in  = rdata_ff.alloc_anchor;
                  res_free_in   = rdata_ff.free_anchor;
               end else begin
                  wr_en         = 1'b1;
                  wr_data       = '{ptr: ptr_ff, alloc_anchor: rdata_ff.alloc_anchor,
                                    free_anchor: anchor_ff};
                  res_status_in = STATUS_RECORDED;
               end
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         mix_cnt_ff   <= '0;
         cnt_ff       <= '0;
         cur_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         mix_cnt_ff   <= mix_cnt_in;
         cnt_ff       <= cnt_in;
         cur_pos_ff   <= cur_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_command;
         ptr_ff    <= req_pointer;
         anchor_ff <= req_anchor;
         hash_ff   <= req_pointer;
      end else if (state_ff == ST_MIX) begin
         hash_ff <= mix_round(hash_ff, mix_cnt_ff);
      end
      res_status_ff <= res_status_in;
      res_alloc_ff  <= res_alloc_in;
      res_free_ff   <= res_free_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_alloc_ff  <= res_alloc_ff;
         rsp_free_ff   <= res_free_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_alloc_anchor_seen = rsp_alloc_ff;
   assign rsp_free_anchor_seen  = rsp_free_ff;

   `PAT_ASSERT_NOW(a_no_req_while_busy, state_ff != ST_IDLE, req_stall)
   `PAT_ASSERT_NOW(a_write_only_clear_or_probe, wr_en, state_ff == ST_CLEAR || state_ff == ST_PROBE)
   `PAT_ASSERT_NOW(a_probe_bounded, state_ff == ST_PROBE, cnt_ff <= LAST_PROBE)
   `PAT_ASSERT_NEXT(a_result_shown, state_ff == ST_DONE && out_free, rsp_valid && state_ff == ST_IDLE)

endmodule

/* test/pointer_allocation_tracker_tb.sv */
// Self-checking testbench for the pointer allocation tracker: directed and random requests.
`timescale 1ns / 1ps

module pointer_allocation_tracker_tb
   import pat_pkg::*;
;

   localparam int SLOT_BITS  = 9;
   localparam int SLOTS      = 1 << SLOT_BITS;
   localparam int CYCLE_CAP  = 4_000_000;
   localparam int DRAIN      = 32;
   localparam int LIGHT_REQS = 550;
   localparam int FULL_REQS  = 300;

   // Tracks what the slot table must hold and the result each request must produce.
   class alloc_scoreboard;
      typedef struct packed {
         logic [STATUS_W-1:0] status;
         logic [ANCHOR_W-1:0] alloc_seen;
         logic [ANCHOR_W-1:0] free_seen;
      } verdict_type;

      typedef enum {LOOKUP_FULL, LOOKUP_HIT, LOOKUP_EMPTY} lookup_type;

      logic [PTR_W-1:0]    slot_ptr   [SLOTS];
      logic [ANCHOR_W-1:0] slot_alloc [SLOTS];
      logic [ANCHOR_W-1:0] slot_free  [SLOTS];
      int                  slots_used;
      int                  requests;
      int                  errors;
      int                  by_status  [8];
      verdict_type         awaited    [$];

      function new();
         foreach (slot_ptr[i]) begin
            slot_ptr[i]   = '0;
            slot_alloc[i] = '0;
            slot_free[i]  = '0;
         end
         foreach (by_status[i]) by_status[i] = 0;
         slots_used = 0;
         requests   = 0;
         errors     = 0;
      endfunction

      function logic [PTR_W-1:0] wang_mix(input logic [PTR_W-1:0] key);
         logic [PTR_W-1:0] v;
         v = key;
         v = ~v + (v << 21);
         v = v ^ (v >> 24);
         v = v + (v << 3) + (v << 8);
         v = v ^ (v >> 14);
         v = v + (v << 2) + (v << 4);
         v = v ^ (v >> 28);
         v = v + (v << 31);
         return v;
      endfunction

      // home slot, then home plus the upper hash bits, then one full circle onward
      function lookup_type lookup(input logic [PTR_W-1:0] p,
                                  output logic [SLOT_BITS-1:0] where);
         logic [PTR_W-1:0]     h;
         logic [SLOT_BITS-1:0] pos;
         h     = wang_mix(p);
         pos   = h[SLOT_BITS-1:0];
         where = '0;
         for (int n = 0; n < SLOTS + 2; n++) begin
            if (n == 1) pos = pos + h[2*SLOT_BITS-1:SLOT_BITS];
            else if (n > 1) pos = pos + 1'b1;
            if (slot_ptr[pos] == p) begin
               where = pos;
               return LOOKUP_HIT;
            end
            if (slot_ptr[pos] == '0) begin
               where = pos;
               return LOOKUP_EMPTY;
            end
         end
         return LOOKUP_FULL;
      endfunction

      function void note_request(input logic cmd, input logic [PTR_W-1:0] p,
                                 input logic [ANCHOR_W-1:0] anc);
         verdict_type          v;
         lookup_type           hit;
         logic [SLOT_BITS-1:0] at;
         v.status     = STATUS_RECORDED;
         v.alloc_seen = NO_ANCHOR;
         v.free_seen  = NO_ANCHOR;
         requests++;
         if (p == '0) begin
            v.status = STATUS_NULL;
         end else if (cmd == CMD_ALLOC) begin
            hit = lookup(p, at);
            if (hit == LOOKUP_FULL) begin
               v.status = STATUS_FULL;
            end else begin
               if (hit == LOOKUP_EMPTY) begin
                  slot_ptr[at] = p;
                  slots_used++;
               end
               slot_alloc[at] = anc;
               slot_free[at]  = NO_ANCHOR;
            end
         end else begin
            hit = lookup(p, at);
            if (hit != LOOKUP_HIT) begin
               v.status = STATUS_UNTRACKED;
            end else if (slot_free[at] != NO_ANCHOR) begin
               v.status     = STATUS_DOUBLE;
               v.alloc_seen = slot_alloc[at];
               v.free_seen  = slot_free[at];
            end else begin
               slot_free[at] = anc;
            end
         end
         awaited.push_back(v);
      endfunction

      function void check_result(input logic [STATUS_W-1:0] status,
                                 input logic [ANCHOR_W-1:0] alloc_seen,
                                 input logic [ANCHOR_W-1:0] free_seen);
         verdict_type w;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result: status %0d alloc %0d free %0d",
                     $time, status, alloc_seen, free_seen);
            errors++;
            return;
         end
         w = awaited.pop_front();
         by_status[w.status]++;
         if (status !== w.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, w.status, status);
            errors++;
         end
         if (alloc_seen !== w.alloc_seen) begin
            $display("%0t: alloc anchor mismatch: expected %0d, actual %0d",
                     $time, w.alloc_seen, alloc_seen);
            errors++;
         end
         if (free_seen !== w.free_seen) begin
            $display("%0t: free anchor mismatch: expected %0d, actual %0d",
                     $time, w.free_seen, free_seen);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = CMD_ALLOC;
   logic [PTR_W-1:0]    req_pointer = '0;
   logic [ANCHOR_W-1:0] req_anchor = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ANCHOR_W-1:0] rsp_alloc_anchor_seen;
   logic [ANCHOR_W-1:0] rsp_free_anchor_seen;

   alloc_scoreboard     sb = new();
   int                  cycles = 0;
   int                  burst_left = 0;
   int                  stall_mode = 0;
   int                  mode_left = 0;
   logic [PTR_W-1:0]    pool [$];

   pointer_allocation_tracker #(
      .INDEX_BITS(SLOT_BITS)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_pointer           (req_pointer),
      .req_anchor            (req_anchor),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_alloc_anchor_seen (rsp_alloc_anchor_seen),
      .rsp_free_anchor_seen  (rsp_free_anchor_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.awaited.size());
         $display("Verification failed");
         $finish;
      end
   end

   // receiver back-pressure: switches between free-running, light, heavy and periodic stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(16, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycles[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_result(rsp_status, rsp_alloc_anchor_seen, rsp_free_anchor_seen);
   end

   task automatic send_request(input logic cmd, input logic [PTR_W-1:0] p,
                               input logic [ANCHOR_W-1:0] anc);
      int gap;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_pointer <= p;
      req_anchor  <= anc;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(cmd, p, anc);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   function automatic logic [PTR_W-1:0] fresh_pointer();
      logic [PTR_W-1:0] p;
      do p = {$urandom, $urandom}; while (p == '0);
      return p;
   endfunction

   function automatic logic [ANCHOR_W-1:0] any_anchor();
      return ANCHOR_W'($urandom_range(0, 65534));
   endfunction

   function automatic logic [PTR_W-1:0] pick_pool();
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   initial begin
      logic [PTR_W-1:0] p_ones;
      logic [PTR_W-1:0] p_one;
      logic [PTR_W-1:0] p_top;
      int               r;

      p_ones = '1;
      p_one  = 64'd1;
      p_top  = 64'h8000_0000_0000_0000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: null pointer, untracked free, double free, realloc, all-ones anchor
      send_request(CMD_ALLOC, '0, 16'd0);
      send_request(CMD_FREE, '0, 16'd65534);
      send_request(CMD_FREE, p_ones, 16'd3);
      send_request(CMD_ALLOC, p_ones, 16'd0);
      send_request(CMD_FREE, p_ones, 16'd65534);
      send_request(CMD_FREE, p_ones, 16'h1234);
      send_request(CMD_ALLOC, p_ones, 16'h5555);
      send_request(CMD_FREE, p_ones, 16'hAAAA);
      send_request(CMD_ALLOC, p_one, 16'd65534);
      send_request(CMD_FREE, p_one, NO_ANCHOR);
      send_request(CMD_FREE, p_one, 16'd7);
      send_request(CMD_FREE, p_one, 16'd9);
      send_request(CMD_ALLOC, p_top, NO_ANCHOR);
      send_request(CMD_FREE, p_top, 16'd1);
      send_request(CMD_FREE, p_top, 16'd2);
      send_request(CMD_ALLOC, p_ones, 16'h00FF);
      send_request(CMD_FREE, p_ones, 16'h0F0F);
      send_request(CMD_ALLOC, p_top, 16'd0);

      pool.push_back(p_ones);
      pool.push_back(p_one);
      pool.push_back(p_top);
      repeat (40) pool.push_back(fresh_pointer());

      // light load: alloc/free traffic on a small set of pointers, plus some noise
      repeat (LIGHT_REQS) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_request(CMD_ALLOC, pick_pool(), any_anchor());
         else if (r < 80) send_request(CMD_FREE, pick_pool(), any_anchor());
         else if (r < 88) send_request(CMD_FREE, fresh_pointer(), any_anchor());
         else if (r < 94) send_request(1'($urandom_range(0, 1)), '0, any_anchor());
         else begin
            pool.push_back(fresh_pointer());
            send_request(CMD_ALLOC, pool[pool.size() - 1], any_anchor());
         end
      end

      // fill every slot; collisions push probes deep into the linear walk
      while (sb.slots_used < SLOTS) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            pool.push_back(fresh_pointer());
            send_request(CMD_ALLOC, pool[pool.size() - 1], any_anchor());
         end else if (r < 95) begin
            send_request(CMD_FREE, pick_pool(), any_anchor());
         end else if (r < 98) begin
            send_request(CMD_FREE, fresh_pointer(), any_anchor());
         end else begin
            send_request(CMD_ALLOC, '0, any_anchor());
         end
      end

      // full table: new pointers are refused, tracked ones still work
      repeat (FULL_REQS) begin
         r = $urandom_range(0, 99);
         if (r < 30) send_request(CMD_ALLOC, fresh_pointer(), any_anchor());
         else if (r < 55) send_request(CMD_ALLOC, pick_pool(), any_anchor());
         else if (r < 85) send_request(CMD_FREE, pick_pool(), any_anchor());
         else if (r < 95) send_request(CMD_FREE, fresh_pointer(), any_anchor());
         else send_request(1'($urandom_range(0, 1)), '0, any_anchor());
      end

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d requests; the %0d-slot table ended with %0d slots in use.",
               sb.requests, SLOTS, sb.slots_used);
      $display("Results: %0d recorded, %0d table full, %0d double free, %0d untracked, %0d null",
               sb.by_status[STATUS_RECORDED], sb.by_status[STATUS_FULL],
               sb.by_status[STATUS_DOUBLE], sb.by_status[STATUS_UNTRACKED],
               sb.by_status[STATUS_NULL]);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
